// ----- hdl/deq_pkg.sv -----
// Shared types and constants for the double-ended queue.
// Used by deq_cell and double_ended_queue; depends on nothing.
`default_nettype none

package deq_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_QUERY      = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_data    value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- hdl/deq_cell.sv -----
// One storage cell of the queue chain: a valid bit and one element.
// Trades data with its left and right neighbors; uses deq_pkg.
`default_nettype none

module deq_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire deq_pkg::t_cell_ctrl  i_ctrl,
    input  wire                  i_left_valid,
    input  wire deq_pkg::t_data  i_left_data,
    input  wire                  i_right_valid,
    input  wire deq_pkg::t_data  i_right_data,
    output logic                 o_valid,
    output deq_pkg::t_data       o_data,
    output deq_pkg::t_data       o_tap
);
    import deq_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_data r_data;
    t_data n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        case (i_ctrl.op)
            OP_PUSH_FRONT: begin
                n_valid = i_left_valid;
                n_data  = i_left_data;
            end
            OP_PUSH_BACK: begin
                if (!r_valid && i_left_valid) begin
                    n_valid = 1'b1;
                    n_data  = i_ctrl.value;
                end
            end
            OP_POP_FRONT: begin
                n_valid = i_right_valid;
                n_data  = i_right_data;
            end
            OP_POP_BACK: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            OP_CLEAR: n_valid = 1'b0;
            default: begin
                n_valid = r_valid;
                n_data  = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_tap   = (r_valid && !i_right_valid) ? r_data : '0;

endmodule

`default_nettype wire

// ----- hdl/double_ended_queue.sv -----
// Top level of the double-ended queue: command decode, entry count and result register.
// Instantiates a chain of DEPTH deq_cell elements; uses deq_pkg.
`default_nettype none

// Bounded deque of signed 32-bit values held in a row of DEPTH cells, packed from
// cell 0 (front) upward. A push at the front shifts the whole row one cell right, a
// pop at the front shifts it one cell left, and the back is the last valid cell.
// Each request gives one result, and a new request is taken in every cycle while
// results are drained: the cells update at the edge that takes the request, and the
// result register samples them when it next loads. Front and back read 0 when
// the queue is empty; a pop on empty and a push on full leave the queue unchanged
// and report it in o_status. Commands 6 and 7 act as a query.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [2:0]                         i_command,
    input  wire  signed [deq_pkg::DATA_W-1:0]  i_value,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic signed [deq_pkg::DATA_W-1:0]  o_front_value,
    output logic signed [deq_pkg::DATA_W-1:0]  o_back_value,
    output logic [$clog2(DEPTH+1)-1:0]         o_occupancy,
    output logic                               o_is_empty,
    output logic [1:0]                         o_status
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_pend;
    t_status          r_status;
    t_status          n_status;
    logic             r_out_valid;
    t_cell_ctrl       w_ctrl;
    logic             w_load;
    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_data            w_back;

    logic  w_cell_valid [DEPTH];
    t_data w_cell_data  [DEPTH];
    t_data w_tap        [DEPTH];

    assign w_load   = r_pend && (!r_out_valid || i_ready);
    assign o_ready  = !r_pend || w_load;
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    always_comb begin
        w_ctrl.op    = OP_HOLD;
        w_ctrl.value = i_value;
        n_count      = r_count;
        n_status     = ST_OK;
        if (w_accept) begin
            case (i_command)
                CMD_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.op = OP_PUSH_FRONT;
                        n_count   = r_count + 1'b1;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.op = OP_PUSH_BACK;
                        n_count   = r_count + 1'b1;
                    end
                end
                CMD_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctrl.op = OP_POP_FRONT;
                        n_count   = r_count - 1'b1;
                    end
                end
                CMD_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctrl.op = OP_POP_BACK;
                        n_count   = r_count - 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    w_ctrl.op = OP_CLEAR;
                    n_count   = '0;
                end
                default: begin
                    w_ctrl.op = OP_HOLD;
                end
            endcase
        end
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic  w_left_valid;
        t_data w_left_data;
        logic  w_right_valid;
        t_data w_right_data;

        if (gi == 0) begin : g_head
            assign w_left_valid = 1'b1;
            assign w_left_data  = i_value;
        end else begin : g_mid
            assign w_left_valid = w_cell_valid[gi-1];
            assign w_left_data  = w_cell_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_right_valid = 1'b0;
            assign w_right_data  = '0;
        end else begin : g_inner
            assign w_right_valid = w_cell_valid[gi+1];
            assign w_right_data  = w_cell_data[gi+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_valid  (w_left_valid),
            .i_left_data   (w_left_data),
            .i_right_valid (w_right_valid),
            .i_right_data  (w_right_data),
            .o_valid       (w_cell_valid[gi]),
            .o_data        (w_cell_data[gi]),
            .o_tap         (w_tap[gi])
        );
    end

    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | w_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count  <= n_count;
                r_status <= n_status;
            end
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_front_value <= w_cell_valid[0] ? w_cell_data[0] : '0;
            o_back_value  <= w_back;
            o_occupancy   <= r_count;
            o_is_empty    <= w_empty;
            o_status      <= r_status;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for double_ended_queue: random and directed requests, with idling
// on both sides. Predicts every result and checks it field by field. Depends on deq_pkg.
module tb;
    import deq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int REQ_TARGET = 1250;
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_LEN   = 80;
    localparam int CALM_LO    = 500;
    localparam int CALM_HI    = 700;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0] cmd;
        t_data      value;
    } t_deq_req;

    typedef struct packed {
        t_data      front;
        t_data      back;
        logic [4:0] occupancy;
        logic       empty;
        logic [1:0] status;
    } t_deq_view;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [2:0]           i_command = CMD_QUERY;
    t_data                i_value = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_data                o_front_value;
    t_data                o_back_value;
    logic [4:0]           o_occupancy;
    logic                 o_is_empty;
    logic [1:0]           o_status;

    t_deq_req  cmd_backlog[$];
    t_deq_view pending_views[$];

    t_data      mirror_store[DEPTH];
    logic [3:0] mirror_head = '0;
    logic [4:0] mirror_count = '0;

    int sent_cnt = 0;
    int taken_cnt = 0;
    int req_total = 0;
    int mismatches = 0;
    int cycle_cnt = 0;

    double_ended_queue #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic deque_apply(input logic [2:0] cmd, input t_data val);
        t_deq_view  view;
        logic [1:0] st;
        logic [3:0] tail;
        st = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (mirror_count == DEPTH) begin
                    st = ST_FULL;
                end else begin
                    mirror_head = mirror_head - 4'd1;
                    mirror_store[mirror_head] = val;
                    mirror_count = mirror_count + 5'd1;
                end
            end
            CMD_PUSH_BACK: begin
                if (mirror_count == DEPTH) begin
                    st = ST_FULL;
                end else begin
                    tail = mirror_head + mirror_count[3:0];
                    mirror_store[tail] = val;
                    mirror_count = mirror_count + 5'd1;
                end
            end
            CMD_POP_FRONT: begin
                if (mirror_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    mirror_head = mirror_head + 4'd1;
                    mirror_count = mirror_count - 5'd1;
                end
            end
            CMD_POP_BACK: begin
                if (mirror_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    mirror_count = mirror_count - 5'd1;
                end
            end
            CMD_CLEAR: begin
                mirror_count = '0;
                mirror_head = '0;
            end
            default: begin
            end
        endcase
        if (mirror_count == 0) begin
            view.front = '0;
            view.back = '0;
            view.empty = 1'b1;
        end else begin
            tail = mirror_head + mirror_count[3:0] - 4'd1;
            view.front = mirror_store[mirror_head];
            view.back = mirror_store[tail];
            view.empty = 1'b0;
        end
        view.occupancy = mirror_count;
        view.status = st;
        pending_views.push_back(view);
    endtask

    function automatic t_data pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 32'sh7fff_ffff;
        if (r < 16) return 32'sh8000_0000;
        if (r < 20) return '0;
        if (r < 24) return -32'sd1;
        return $urandom;
    endfunction

    function automatic logic [2:0] pick_push();
        return $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    function automatic logic [2:0] pick_cmd(input int mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            0, 1, 2: return (r < 85) ? pick_push() : ((r < 93) ? pick_pop() : CMD_QUERY);
            3, 4:    return (r < 85) ? pick_pop() : ((r < 95) ? pick_push() : CMD_QUERY);
            8:       return 3'($urandom_range(7));
            default: return (r < 45) ? pick_push() : ((r < 90) ? pick_pop() : CMD_QUERY);
        endcase
    endfunction

    task automatic queue_req(input logic [2:0] cmd, input t_data val);
        t_deq_req req;
        req.cmd = cmd;
        req.value = val;
        cmd_backlog.push_back(req);
    endtask

    // driver
    always @(negedge i_clk) begin : drive_requests
        t_deq_req req;
        if (i_rst_n && !(i_valid && taken_cnt != sent_cnt)) begin
            if (cmd_backlog.size() > 0 &&
                ((taken_cnt >= CALM_LO && taken_cnt < CALM_HI) || $urandom_range(99) >= 22)) begin
                req = cmd_backlog.pop_front();
                i_command <= req.cmd;
                i_value <= req.value;
                i_valid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver, with long hold-offs to back up the queue
    always @(negedge i_clk) begin : drive_ready
        int  hold_left;
        bit  first_done;
        bit  second_done;
        if (i_rst_n) begin
            if (!first_done && taken_cnt >= 200) begin
                first_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (!second_done && taken_cnt >= 900) begin
                second_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_ready <= 1'b0;
            end else if (taken_cnt >= CALM_LO && taken_cnt < CALM_HI) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= 22);
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : watch_ports
        t_deq_view want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_views.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: front=%0d back=%0d occ=%0d",
                                 o_front_value, o_back_value, o_occupancy);
                    mismatches++;
                end else begin
                    want = pending_views.pop_front();
                    if (o_front_value !== want.front || o_back_value !== want.back ||
                        o_occupancy !== want.occupancy || o_is_empty !== want.empty ||
                        o_status !== want.status) begin
                        if (mismatches < 10)
                            $display({"result mismatch: front %0d/%0d back %0d/%0d ",
                                      "occ %0d/%0d empty %0b/%0b status %0d/%0d (exp/act)"},
                                     want.front, o_front_value, want.back, o_back_value,
                                     want.occupancy, o_occupancy, want.empty, o_is_empty,
                                     want.status, o_status);
                        mismatches++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                deque_apply(i_command, i_value);
                taken_cnt <= taken_cnt + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int mode;
        int len;
        queue_req(CMD_POP_FRONT, pick_value());
        queue_req(CMD_POP_BACK, pick_value());
        queue_req(CMD_QUERY, '0);
        queue_req(CMD_PUSH_FRONT, 32'sh7fff_ffff);
        queue_req(CMD_PUSH_BACK, 32'sh8000_0000);
        queue_req(CMD_PUSH_FRONT, '0);
        queue_req(CMD_PUSH_BACK, -32'sd1);
        queue_req(CMD_QUERY, 32'sh1234_5678);
        queue_req(CMD_SPARE_A, 32'sh5555_5555);
        queue_req(CMD_SPARE_B, 32'shaaaa_aaaa);
        queue_req(CMD_POP_FRONT, '0);
        queue_req(CMD_POP_BACK, '0);
        queue_req(CMD_CLEAR, -32'sd1);
        queue_req(CMD_POP_FRONT, '0);
        queue_req(CMD_PUSH_BACK, 32'sh5555_5555);
        queue_req(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
        queue_req(CMD_POP_BACK, '0);
        queue_req(CMD_POP_FRONT, '0);
        queue_req(CMD_POP_BACK, '0);
        while (cmd_backlog.size() < REQ_TARGET) begin
            mode = $urandom_range(9);
            len = $urandom_range(8, 28);
            if (mode == 9)
                queue_req(CMD_CLEAR, pick_value());
            repeat (len) queue_req(pick_cmd(mode), pick_value());
        end
        req_total = cmd_backlog.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (taken_cnt < req_total || pending_views.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
